### rtl/scsc_pkg.sv
// Shared types and constants for the swept circle / segment collision block.
// Used by every module under rtl; depends on nothing else.
package scsc_pkg;

  // Number of register stages from input to result register
  localparam int unsigned NUM_STAGES = 7;
  // Stages held by the front end; the rest belong to the wide compare
  localparam int unsigned FRONT_STAGES = 4;

  // Widths of the arithmetic along the datapath
  localparam int unsigned COORD_W = 16;
  localparam int unsigned RAD_W   = 15;
  localparam int unsigned DIFF_W  = COORD_W + 1;   // difference of two coordinates
  localparam int unsigned PROD_W  = 2 * DIFF_W - 1; // signed product of two differences
  localparam int unsigned SQ_W    = PROD_W - 1;     // square of a difference
  localparam int unsigned CROSS_W = PROD_W + 1;     // sum or difference of two products
  localparam int unsigned SUMSQ_W = SQ_W + 1;       // sum of two squares
  localparam int unsigned R2_W    = 2 * RAD_W;
  localparam int unsigned HALF_LO = 17;             // low half width when splitting 33 bits
  localparam int unsigned HALF_HI = SUMSQ_W - HALF_LO;
  localparam int unsigned LHS_W   = 2 * SUMSQ_W;    // |cross|^2
  localparam int unsigned RHS_W   = R2_W + SUMSQ_W; // r^2 * |AB|^2

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_SWEPT    = 2'd1,
    KIND_ENDPOINT = 2'd2,
    KIND_BODY     = 2'd3
  } kind_t;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

  // What the front end hands to the wide body compare
  typedef struct packed {
    kind_t                kind_pre;  // decision without the body test
    logic                 body_cand; // body test still open
    logic [SUMSQ_W-1:0]   abs_cross;
    logic [SUMSQ_W-1:0]   len2;
    logic [R2_W-1:0]      r2;
  } front_out_t;

endpackage

### rtl/scsc_pipe_ctrl.sv
// Valid bits and load enables for the collision pipeline.
// Depends on scsc_pkg for the stage count and the control struct.
module scsc_pipe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output scsc_pkg::pipe_ctl_t  ctl
);

  localparam int unsigned N = scsc_pkg::NUM_STAGES;

  logic [N-1:0] vld;
  logic [N-1:0] load;

  // A stage loads when it is empty or its content moves on
  always_comb begin
    load[N-1] = !vld[N-1] || !out_stall;
    for (int i = N - 2; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  assign in_stall  = !load[0];
  assign out_valid = vld[N-1];
  assign ctl.load  = load;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < N; i++) begin
        if (load[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Back pressure only when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld))
    else $error("input stalled with an empty stage");

  // An accepted transfer lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted item lost at first stage");

  // A result held under stall is not dropped
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (vld[N-1] && out_stall) |=> vld[N-1])
    else $error("stalled result dropped");

  // The result register only loads when free or drained
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (vld[N-1] && out_stall) |-> !load[N-1])
    else $error("result register overwritten under stall");

endmodule

### rtl/scsc_front.sv
// Front end: differences, products, sums and the swept, endpoint and range tests.
// Four register stages; depends on scsc_pkg for widths, kinds and structs.
module scsc_front (
  input  logic                                 clk,
  input  scsc_pkg::pipe_ctl_t                  ctl,
  input  logic signed [scsc_pkg::COORD_W-1:0]  prev_x,
  input  logic signed [scsc_pkg::COORD_W-1:0]  prev_y,
  input  logic signed [scsc_pkg::COORD_W-1:0]  cur_x,
  input  logic signed [scsc_pkg::COORD_W-1:0]  cur_y,
  input  logic signed [scsc_pkg::COORD_W-1:0]  center_x,
  input  logic signed [scsc_pkg::COORD_W-1:0]  center_y,
  input  logic        [scsc_pkg::RAD_W-1:0]    circle_radius,
  input  logic signed [scsc_pkg::COORD_W-1:0]  seg_ax,
  input  logic signed [scsc_pkg::COORD_W-1:0]  seg_ay,
  input  logic signed [scsc_pkg::COORD_W-1:0]  seg_bx,
  input  logic signed [scsc_pkg::COORD_W-1:0]  seg_by,
  input  logic        [1:0]                    enable_mask,
  output scsc_pkg::front_out_t                 fo
);

  localparam int unsigned DW = scsc_pkg::DIFF_W;
  localparam int unsigned PW = scsc_pkg::PROD_W;
  localparam int unsigned QW = scsc_pkg::SQ_W;
  localparam int unsigned CW = scsc_pkg::CROSS_W;
  localparam int unsigned SW = scsc_pkg::SUMSQ_W;
  localparam int unsigned RW = scsc_pkg::R2_W;

  function automatic logic signed [PW-1:0] smul(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    smul = PW'(a) * PW'(b);
  endfunction

  function automatic logic [QW-1:0] sqr(input logic signed [DW-1:0] a);
    logic signed [PW-1:0] p;
    p   = PW'(a) * PW'(a);
    sqr = QW'(p);
  endfunction

  // Stage 1: coordinate differences
  logic signed [DW-1:0] mx, my, sx, sy, apx, apy, bpx, bpy, pax, pay, qax, qay;
  logic signed [DW-1:0] dax, day, dbx, dby, wx, wy;
  logic [scsc_pkg::RAD_W-1:0] rad1;
  logic en1;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      mx   <= DW'(cur_x) - DW'(prev_x);
      my   <= DW'(cur_y) - DW'(prev_y);
      sx   <= DW'(seg_bx) - DW'(seg_ax);
      sy   <= DW'(seg_by) - DW'(seg_ay);
      apx  <= DW'(seg_ax) - DW'(prev_x);
      apy  <= DW'(seg_ay) - DW'(prev_y);
      bpx  <= DW'(seg_bx) - DW'(prev_x);
      bpy  <= DW'(seg_by) - DW'(prev_y);
      pax  <= DW'(prev_x) - DW'(seg_ax);
      pay  <= DW'(prev_y) - DW'(seg_ay);
      qax  <= DW'(cur_x) - DW'(seg_ax);
      qay  <= DW'(cur_y) - DW'(seg_ay);
      dax  <= DW'(seg_ax) - DW'(center_x);
      day  <= DW'(seg_ay) - DW'(center_y);
      dbx  <= DW'(seg_bx) - DW'(center_x);
      dby  <= DW'(seg_by) - DW'(center_y);
      wx   <= DW'(center_x) - DW'(seg_ax);
      wy   <= DW'(center_y) - DW'(seg_ay);
      rad1 <= circle_radius;
      en1  <= (enable_mask == 2'b11);
    end
  end

  // Stage 2: products, each into its own register
  logic signed [PW-1:0] pa1, pa2, pb1, pb2, pp1, pp2, pq1, pq2;
  logic signed [PW-1:0] pd1, pd2, pc1, pc2;
  logic [QW-1:0] sq_dax, sq_day, sq_dbx, sq_dby, sq_sx, sq_sy;
  logic [RW-1:0] r2_2;
  logic en2;

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      pa1    <= smul(mx, apy);
      pa2    <= smul(my, apx);
      pb1    <= smul(mx, bpy);
      pb2    <= smul(my, bpx);
      pp1    <= smul(sx, pay);
      pp2    <= smul(sy, pax);
      pq1    <= smul(sx, qay);
      pq2    <= smul(sy, qax);
      pd1    <= smul(sx, wx);
      pd2    <= smul(sy, wy);
      pc1    <= smul(sx, wy);
      pc2    <= smul(sy, wx);
      sq_dax <= sqr(dax);
      sq_day <= sqr(day);
      sq_dbx <= sqr(dbx);
      sq_dby <= sqr(dby);
      sq_sx  <= sqr(sx);
      sq_sy  <= sqr(sy);
      r2_2   <= RW'(rad1) * RW'(rad1);
      en2    <= en1;
    end
  end

  // Stage 3: cross products, squared distances, dot and length
  logic signed [CW-1:0] cr1, cr2, cr3, cr4, dot, crs;
  logic [SW-1:0] da2, db2, len2_3;
  logic [RW-1:0] r2_3;
  logic en3;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      cr1    <= CW'(pa1) - CW'(pa2);
      cr2    <= CW'(pb1) - CW'(pb2);
      cr3    <= CW'(pp1) - CW'(pp2);
      cr4    <= CW'(pq1) - CW'(pq2);
      dot    <= CW'(pd1) + CW'(pd2);
      crs    <= CW'(pc1) - CW'(pc2);
      da2    <= SW'(sq_dax) + SW'(sq_day);
      db2    <= SW'(sq_dbx) + SW'(sq_dby);
      len2_3 <= SW'(sq_sx) + SW'(sq_sy);
      r2_3   <= r2_2;
      en3    <= en2;
    end
  end

  // Stage 4: sign tests, endpoint test and projection range
  logic z1, z2, z3, z4, swept, endp, in_range;
  logic signed [CW-1:0] crs_abs;
  scsc_pkg::kind_t kind_pre;

  always_comb begin
    z1 = (cr1 == '0);
    z2 = (cr2 == '0);
    z3 = (cr3 == '0);
    z4 = (cr4 == '0);
    swept = (z1 || z2 || (cr1[CW-1] != cr2[CW-1])) &&
            (!z3 && !z4 && (cr3[CW-1] != cr4[CW-1]));
    endp = (da2 < SW'(r2_3)) || (db2 < SW'(r2_3));
    in_range = (len2_3 != '0) && !dot[CW-1] && ($unsigned(dot) <= CW'(len2_3));
    crs_abs = crs[CW-1] ? -crs : crs;
    priority if (!en3) begin
      kind_pre = scsc_pkg::KIND_NONE;
    end else if (swept) begin
      kind_pre = scsc_pkg::KIND_SWEPT;
    end else if (endp) begin
      kind_pre = scsc_pkg::KIND_ENDPOINT;
    end else begin
      kind_pre = scsc_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      fo.kind_pre  <= kind_pre;
      fo.body_cand <= en3 && !swept && !endp && in_range;
      fo.abs_cross <= SW'($unsigned(crs_abs));
      fo.len2      <= len2_3;
      fo.r2        <= r2_3;
    end
  end

endmodule

### rtl/scsc_body.sv
// Body test: |cross|^2 < r^2 * |AB|^2 over split partial products, then the result.
// Three register stages; depends on scsc_pkg for widths, kinds and structs.
module scsc_body (
  input  logic                  clk,
  input  scsc_pkg::pipe_ctl_t   ctl,
  input  scsc_pkg::front_out_t  fo,
  output logic                  hit,
  output logic [1:0]            hit_kind
);

  localparam int unsigned LO = scsc_pkg::HALF_LO;
  localparam int unsigned HI = scsc_pkg::HALF_HI;
  localparam int unsigned RW = scsc_pkg::R2_W;
  localparam int unsigned LW = scsc_pkg::LHS_W;
  localparam int unsigned HW = scsc_pkg::RHS_W;
  localparam int unsigned S5 = scsc_pkg::FRONT_STAGES;

  logic [HI-1:0] ah, lh;
  logic [LO-1:0] al, ll;

  assign ah = fo.abs_cross[LO+HI-1:LO];
  assign al = fo.abs_cross[LO-1:0];
  assign lh = fo.len2[LO+HI-1:LO];
  assign ll = fo.len2[LO-1:0];

  // Stage 5: partial products
  logic [2*HI-1:0]  p_hh;
  logic [HI+LO-1:0] p_hl;
  logic [2*LO-1:0]  p_ll;
  logic [RW+HI-1:0] q_h;
  logic [RW+LO-1:0] q_l;
  scsc_pkg::kind_t  kind5;
  logic             cand5;

  always_ff @(posedge clk) begin
    if (ctl.load[S5]) begin
      p_hh  <= (2*HI)'(ah) * (2*HI)'(ah);
      p_hl  <= (HI+LO)'(ah) * (HI+LO)'(al);
      p_ll  <= (2*LO)'(al) * (2*LO)'(al);
      q_h   <= (RW+HI)'(fo.r2) * (RW+HI)'(lh);
      q_l   <= (RW+LO)'(fo.r2) * (RW+LO)'(ll);
      kind5 <= fo.kind_pre;
      cand5 <= fo.body_cand;
    end
  end

  // Stage 6: assemble both sides
  logic [LW-1:0]   lhs;
  logic [HW-1:0]   rhs;
  scsc_pkg::kind_t kind6;
  logic            cand6;

  always_ff @(posedge clk) begin
    if (ctl.load[S5+1]) begin
      lhs   <= (LW'(p_hh) << (2*LO)) + (LW'(p_hl) << (LO+1)) + LW'(p_ll);
      rhs   <= (HW'(q_h) << LO) + HW'(q_l);
      kind6 <= kind5;
      cand6 <= cand5;
    end
  end

  // Stage 7: compare and pick the result
  scsc_pkg::kind_t kind_next;
  scsc_pkg::kind_t kind;

  always_comb begin
    if (cand6 && (lhs < LW'(rhs))) begin
      kind_next = scsc_pkg::KIND_BODY;
    end else begin
      kind_next = kind6;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[S5+2]) begin
      kind <= kind_next;
    end
  end

  assign hit_kind = kind;
  assign hit      = (kind != scsc_pkg::KIND_NONE);

endmodule

### rtl/swept_circle_segment_collision_top.sv
// Swept circle versus line segment collision test, top level.
// Depends on scsc_pkg, scsc_pipe_ctrl, scsc_front and scsc_body.
//
// Usage:
//   Input channel: in_valid / in_stall with one query per transfer: previous
//   and current circle position, centre, radius, segment A-B and enable_mask.
//   Output channel: out_valid / out_stall with hit and hit_kind (0 none,
//   1 swept crossing, 2 endpoint inside, 3 segment body) per query, in order.
//   Throughput: one query per cycle sustained while out_stall stays low, with no
//   gaps between transfers. Each query passes through seven register stages
//   (differences, products, sums, tests, partial products of the 66-bit body
//   compare, its sums, and the result register); the first stage loads at
//   the input transfer edge.
//   The widest multiply is 30 x 17 bits; the |cross|^2 and r^2*|AB|^2 terms
//   are split into halves for that reason.
//   When out_stall is high the result holds; empty stages still fill, so
//   in_stall rises only once all seven stages hold a query.
//   Reset (rst, synchronous, active high) empties every stage; there is no
//   state between queries.
module swept_circle_segment_collision_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [scsc_pkg::COORD_W-1:0]  prev_x,
  input  logic signed [scsc_pkg::COORD_W-1:0]  prev_y,
  input  logic signed [scsc_pkg::COORD_W-1:0]  cur_x,
  input  logic signed [scsc_pkg::COORD_W-1:0]  cur_y,
  input  logic signed [scsc_pkg::COORD_W-1:0]  center_x,
  input  logic signed [scsc_pkg::COORD_W-1:0]  center_y,
  input  logic        [scsc_pkg::RAD_W-1:0]    circle_radius,
  input  logic signed [scsc_pkg::COORD_W-1:0]  seg_ax,
  input  logic signed [scsc_pkg::COORD_W-1:0]  seg_ay,
  input  logic signed [scsc_pkg::COORD_W-1:0]  seg_bx,
  input  logic signed [scsc_pkg::COORD_W-1:0]  seg_by,
  input  logic        [1:0]                    enable_mask,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 hit,
  output logic        [1:0]                    hit_kind
);

  scsc_pkg::pipe_ctl_t  ctl;
  scsc_pkg::front_out_t fo;

  // Valid bits and stage load enables
  scsc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Differences, products and the early tests
  scsc_front u_front (
    .clk           (clk),
    .ctl           (ctl),
    .prev_x        (prev_x),
    .prev_y        (prev_y),
    .cur_x         (cur_x),
    .cur_y         (cur_y),
    .center_x      (center_x),
    .center_y      (center_y),
    .circle_radius (circle_radius),
    .seg_ax        (seg_ax),
    .seg_ay        (seg_ay),
    .seg_bx        (seg_bx),
    .seg_by        (seg_by),
    .enable_mask   (enable_mask),
    .fo            (fo)
  );

  // Wide body compare and result register
  scsc_body u_body (
    .clk      (clk),
    .ctl      (ctl),
    .fo       (fo),
    .hit      (hit),
    .hit_kind (hit_kind)
  );

endmodule

### test/testbench.sv
// Self-checking testbench for swept_circle_segment_collision_top.
// Depends on scsc_pkg for the coordinate widths and the hit kind codes.
// Runs a table of directed queries, then random ones, both with random idling.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NUM_DIRECTED = 21;
  localparam int unsigned NUM_RANDOM   = 1750;
  localparam int unsigned MAX_IDLE     = 19;
  localparam int unsigned DRAIN_CYCLES = 2 * scsc_pkg::NUM_STAGES;
  localparam int unsigned COORD_MAX    = 32767;
  localparam int unsigned RAD_MAX      = 32767;
  localparam logic [1:0]  BOTH_ENABLED = 2'b11;
  localparam int unsigned CRD_W        = scsc_pkg::COORD_W;
  localparam int unsigned RAD_W        = scsc_pkg::RAD_W;

  // One collision query as it appears on the input ports
  typedef struct packed {
    logic signed [CRD_W-1:0] prev_x;
    logic signed [CRD_W-1:0] prev_y;
    logic signed [CRD_W-1:0] cur_x;
    logic signed [CRD_W-1:0] cur_y;
    logic signed [CRD_W-1:0] center_x;
    logic signed [CRD_W-1:0] center_y;
    logic        [RAD_W-1:0] circle_radius;
    logic signed [CRD_W-1:0] seg_ax;
    logic signed [CRD_W-1:0] seg_ay;
    logic signed [CRD_W-1:0] seg_bx;
    logic signed [CRD_W-1:0] seg_by;
    logic        [1:0]       enable_mask;
  } query_t;

  // Directed row: the query and, where obvious, the kind it must give
  typedef struct {
    query_t          q;
    bit              typed;
    scsc_pkg::kind_t kind;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [CRD_W-1:0] prev_x;
  logic signed [CRD_W-1:0] prev_y;
  logic signed [CRD_W-1:0] cur_x;
  logic signed [CRD_W-1:0] cur_y;
  logic signed [CRD_W-1:0] center_x;
  logic signed [CRD_W-1:0] center_y;
  logic        [RAD_W-1:0] circle_radius;
  logic signed [CRD_W-1:0] seg_ax;
  logic signed [CRD_W-1:0] seg_ay;
  logic signed [CRD_W-1:0] seg_bx;
  logic signed [CRD_W-1:0] seg_by;
  logic        [1:0]       enable_mask;
  logic                    out_valid;
  logic                    out_stall;
  logic                    hit;
  logic        [1:0]       hit_kind;

  query_t          pins;
  bit              drv_typed;
  scsc_pkg::kind_t drv_kind;
  scsc_pkg::kind_t expected_kinds [$];
  scsc_pkg::kind_t want_kind;
  int              mismatches = 0;
  bit              in_burst;
  bit              out_burst;
  dir_row_t        dir_tab [NUM_DIRECTED];

  swept_circle_segment_collision_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .prev_x        (prev_x),
    .prev_y        (prev_y),
    .cur_x         (cur_x),
    .cur_y         (cur_y),
    .center_x      (center_x),
    .center_y      (center_y),
    .circle_radius (circle_radius),
    .seg_ax        (seg_ax),
    .seg_ay        (seg_ay),
    .seg_bx        (seg_bx),
    .seg_by        (seg_by),
    .enable_mask   (enable_mask),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .hit_kind      (hit_kind)
  );

  assign pins = {prev_x, prev_y, cur_x, cur_y, center_x, center_y, circle_radius,
                 seg_ax, seg_ay, seg_bx, seg_by, enable_mask};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int sign_of(longint v);
    return int'(v > 0) - int'(v < 0);
  endfunction

  function automatic longint cross2d(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  // Work out which test fires first for one query
  function automatic scsc_pkg::kind_t collision_kind(query_t q);
    longint       px, py, qx, qy, cx, cy, ax, ay, bx, by;
    longint       mx, my, sx, sy, wx, wy, r2, dot, len2, cr;
    int           s1, s2, s3, s4;
    logic [127:0] lhs, rhs;
    px = q.prev_x;   py = q.prev_y;
    qx = q.cur_x;    qy = q.cur_y;
    cx = q.center_x; cy = q.center_y;
    ax = q.seg_ax;   ay = q.seg_ay;
    bx = q.seg_bx;   by = q.seg_by;
    r2 = longint'(q.circle_radius) * longint'(q.circle_radius);
    if (q.enable_mask != BOTH_ENABLED) return scsc_pkg::KIND_NONE;

    // path crossing the segment
    mx = qx - px; my = qy - py;
    sx = bx - ax; sy = by - ay;
    s1 = sign_of(cross2d(mx, my, ax - px, ay - py));
    s2 = sign_of(cross2d(mx, my, bx - px, by - py));
    s3 = sign_of(cross2d(sx, sy, px - ax, py - ay));
    s4 = sign_of(cross2d(sx, sy, qx - ax, qy - ay));
    if (s1 * s2 <= 0 && s3 * s4 < 0) return scsc_pkg::KIND_SWEPT;

    // either end strictly inside the circle
    if ((ax - cx) * (ax - cx) + (ay - cy) * (ay - cy) < r2 ||
        (bx - cx) * (bx - cx) + (by - cy) * (by - cy) < r2)
      return scsc_pkg::KIND_ENDPOINT;

    // centre projects onto the segment and lies closer than r
    wx = cx - ax; wy = cy - ay;
    dot  = sx * wx + sy * wy;
    len2 = sx * sx + sy * sy;
    if (len2 > 0 && dot >= 0 && dot <= len2) begin
      cr = cross2d(sx, sy, wx, wy);
      if (cr < 0) cr = -cr;
      lhs = cr;
      lhs = lhs * lhs;
      rhs = r2;
      rhs = rhs * len2;
      if (lhs < rhs) return scsc_pkg::KIND_BODY;
    end
    return scsc_pkg::KIND_NONE;
  endfunction

  // Value within span of base, clamped to the coordinate range
  function automatic logic [CRD_W-1:0] near(int base, int span);
    int v;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v > int'(COORD_MAX)) v = COORD_MAX;
    else if (v < -int'(COORD_MAX) - 1) v = -int'(COORD_MAX) - 1;
    return v[CRD_W-1:0];
  endfunction

  // Random query: either raw bits, or geometry packed into one box
  function automatic query_t random_query();
    query_t q;
    int     spans [4];
    int     span, base;
    spans = '{COORD_MAX, 4096, 256, 16};
    q = {1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 9) < 2) return q;

    span = spans[$urandom_range(0, 3)];
    base = int'($urandom_range(0, 65535)) - 32768;
    q.prev_x   = near(base, span); q.prev_y   = near(base, span);
    q.cur_x    = near(base, span); q.cur_y    = near(base, span);
    q.center_x = near(base, span); q.center_y = near(base, span);
    q.seg_ax   = near(base, span); q.seg_ay   = near(base, span);
    q.seg_bx   = near(base, span); q.seg_by   = near(base, span);
    q.circle_radius = RAD_W'($urandom_range(0, span));
    case ($urandom_range(0, 9))
      0: begin
        q.seg_bx = q.seg_ax; q.seg_by = q.seg_ay;
      end
      1: begin
        q.cur_x = q.prev_x; q.cur_y = q.prev_y;
      end
      2: begin
        q.center_x = near(q.seg_ax, 2); q.center_y = near(q.seg_ay, 2);
      end
      3: begin
        q.center_x = near((int'(q.seg_ax) + int'(q.seg_bx)) / 2, 2);
        q.center_y = near((int'(q.seg_ay) + int'(q.seg_by)) / 2, 2);
      end
      4: begin
        q.center_x = q.cur_x; q.center_y = q.cur_y;
      end
      default: ;
    endcase
    q.enable_mask = ($urandom_range(0, 9) == 0) ? 2'($urandom) : BOTH_ENABLED;
    return q;
  endfunction

  // Present one query after a random gap and hold it until the transfer
  task automatic send_query(query_t q, bit typed, scsc_pkg::kind_t kind);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_IDLE);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    prev_x        <= q.prev_x;
    prev_y        <= q.prev_y;
    cur_x         <= q.cur_x;
    cur_y         <= q.cur_y;
    center_x      <= q.center_x;
    center_y      <= q.center_y;
    circle_radius <= q.circle_radius;
    seg_ax        <= q.seg_ax;
    seg_ay        <= q.seg_ay;
    seg_bx        <= q.seg_bx;
    seg_by        <= q.seg_by;
    enable_mask   <= q.enable_mask;
    drv_typed     <= typed;
    drv_kind      <= kind;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
  endtask

  // Stimulus: reset, directed table, random queries, drain
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    {prev_x, prev_y, cur_x, cur_y, center_x, center_y} = '0;
    {circle_radius, seg_ax, seg_ay, seg_bx, seg_by, enable_mask} = '0;
    drv_typed = 1'b0;
    drv_kind = scsc_pkg::KIND_NONE;
    in_burst = 1'b0;

    // prev, cur, centre, radius, A, B, enable
    dir_tab[0]  = '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3}, 1, scsc_pkg::KIND_NONE};
    dir_tab[1]  = '{'{-100, 0, 100, 0, 1000, 1000, 1, 0, -100, 0, 100, 0},
                    1, scsc_pkg::KIND_NONE};
    dir_tab[2]  = '{'{-100, 0, 100, 0, 1000, 1000, 1, 0, -100, 0, 100, 1},
                    1, scsc_pkg::KIND_NONE};
    dir_tab[3]  = '{'{-100, 0, 100, 0, 1000, 1000, 1, 0, -100, 0, 100, 2},
                    1, scsc_pkg::KIND_NONE};
    dir_tab[4]  = '{'{-100, 0, 100, 0, 1000, 1000, 1, 0, -100, 0, 100, 3},
                    1, scsc_pkg::KIND_SWEPT};
    dir_tab[5]  = '{'{5000, 5000, 5000, 5000, 0, 0, 20, 10, 0, 1000, 0, 3},
                    1, scsc_pkg::KIND_ENDPOINT};
    dir_tab[6]  = '{'{5000, 5000, 5000, 5000, 0, 0, 20, 1000, 0, 0, -5, 3},
                    1, scsc_pkg::KIND_ENDPOINT};
    dir_tab[7]  = '{'{5000, 5000, 5000, 5000, 0, 0, 100, -1000, 50, 1000, 50, 3},
                    1, scsc_pkg::KIND_BODY};
    // zero-length segment outside the circle
    dir_tab[8]  = '{'{5000, 5000, 5000, 5000, 0, 0, 100, 200, 0, 200, 0, 3},
                    1, scsc_pkg::KIND_NONE};
    // segment tangent to the circle, end on its rim
    dir_tab[9]  = '{'{5000, 5000, 5000, 5000, 0, 0, 16, 16, 0, 16, 5000, 3},
                    1, scsc_pkg::KIND_NONE};
    // zero radius with the centre on the segment
    dir_tab[10] = '{'{5000, 5000, 5000, 5000, 0, 0, 0, -100, 0, 100, 0, 3},
                    1, scsc_pkg::KIND_NONE};
    // path passes exactly through A
    dir_tab[11] = '{'{-10, 0, 10, 0, 20000, 20000, 0, 0, 0, 0, 100, 3},
                    1, scsc_pkg::KIND_SWEPT};
    // path ends on the segment
    dir_tab[12] = '{'{-10, 50, 0, 50, 20000, 20000, 0, 0, 0, 0, 100, 3},
                    1, scsc_pkg::KIND_NONE};
    // centre projects past B
    dir_tab[13] = '{'{5000, 5000, 5000, 5000, 200, 10, 50, 0, 0, 100, 0, 3},
                    1, scsc_pkg::KIND_NONE};
    dir_tab[14] = '{'{-32768, -32768, 32767, 32767, 32767, 32767, 0,
                      -32768, 32767, 32767, -32768, 3}, 1, scsc_pkg::KIND_SWEPT};
    dir_tab[15] = '{'{-32768, -32768, -32768, -32768, -32768, -32768, 32767,
                      -32768, -32768, -32768, -32768, 3}, 1, scsc_pkg::KIND_ENDPOINT};
    dir_tab[16] = '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767,
                      32767, 32767, 32767, 32767, 3}, 1, scsc_pkg::KIND_ENDPOINT};
    dir_tab[17] = '{'{32767, -32768, 32767, -32768, -32768, 32767, 32767,
                      -32768, -32768, 32767, 32767, 3}, 0, scsc_pkg::KIND_NONE};
    // motion collinear with the segment
    dir_tab[18] = '{'{-50, 0, 50, 0, 0, 3000, 0, -100, 0, 100, 0, 3},
                    0, scsc_pkg::KIND_NONE};
    dir_tab[19] = '{'{32767, 32767, -32768, -32768, 0, 0, 32767,
                      32767, -32768, -32768, 32767, 3}, 0, scsc_pkg::KIND_NONE};
    // motion parallel to the segment, centre on it
    dir_tab[20] = '{'{-100, 10, 100, 10, 0, 0, 5, -100, 0, 100, 0, 3},
                    0, scsc_pkg::KIND_NONE};

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_query(dir_tab[i].q, dir_tab[i].typed, dir_tab[i].kind);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // alternate between idling and back-to-back stretches
      if (i % 100 == 0) in_burst = ($urandom_range(0, 3) == 0);
      send_query(random_query(), 1'b0, scsc_pkg::KIND_NONE);
    end

    @(negedge clk) in_valid <= 1'b0;
    while (expected_kinds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: stall for a random count, then take one transfer
  initial begin
    int n;
    int taken;
    out_stall = 1'b0;
    out_burst = 1'b0;
    taken = 0;
    wait (!rst);
    forever begin
      if (taken % 100 == 0) out_burst = ($urandom_range(0, 3) == 0);
      n = out_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (n > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Predict on each input transfer, check on each result transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_kinds.push_back(drv_typed ? drv_kind : collision_kind(pins));
      if (out_valid && !out_stall) begin
        if (expected_kinds.size() == 0) begin
          $error("result with nothing pending: hit=%0b hit_kind=%0d", hit, hit_kind);
          mismatches++;
        end else begin
          want_kind = expected_kinds.pop_front();
          if (hit !== (want_kind != scsc_pkg::KIND_NONE)) begin
            $error("hit: expected %0b, actual %0b",
                   want_kind != scsc_pkg::KIND_NONE, hit);
            mismatches++;
          end
          if (hit_kind !== want_kind) begin
            $error("hit_kind: expected %0d, actual %0d", want_kind, hit_kind);
            mismatches++;
          end
        end
      end
    end
  end

  // Hard stop in case the handshake hangs
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
